[rtl/encoder_speed_averager_macros.svh]
// Assertion macros used by the checker file.
`ifndef ENCODER_SPEED_AVERAGER_MACROS_SVH
`define ENCODER_SPEED_AVERAGER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ESA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ESA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/esa_pkg.sv]
package esa_pkg;

	// Field widths
	localparam int ANGLE_W  = 14;
	localparam int TIME_W   = 16;
	localparam int SPEED_W  = 24;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;

	// Accumulator widths (up to 128 pairs per window)
	localparam int COUNT_W = 7;
	localparam int DIFF_W  = 16;
	localparam int ASUM_W  = 22;
	localparam int TSUM_W  = 23;

	// Divider widths: numerator = |angle_sum| * 256e6, denominator = 16383 * time_sum
	localparam int MAG_W   = 22;
	localparam int NUM_W   = 49;
	localparam int DEN_W   = 37;
	localparam int QUO_W   = 25;
	localparam int STEP_W  = 6;
	localparam int DIV_STEPS = NUM_W;

	localparam logic [27:0] NUM_SCALE = 28'd256000000;
	localparam logic [DIFF_W-1:0] ANGLE_SPAN = 16'd16383;

	// Saturation limits of the speed magnitude
	localparam logic [QUO_W-1:0] SPEED_POS_MAX = 25'd8388607;
	localparam logic [QUO_W-1:0] SPEED_NEG_MAX = 25'd8388608;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD = 1'd1;

	// Register reset values
	localparam logic [TIME_W-1:0]  MAX_INTERVAL_RST   = 16'd2500;
	localparam logic [ANGLE_W-1:0] WRAP_THRESHOLD_RST = 14'd10467;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accum;
		logic load;
		logic step;
		logic emit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic window_done;
	} stat_t;

endpackage

[rtl/esa_pair_if.sv]
interface esa_pair_if;
	logic valid;
	logic ready;
	logic [esa_pkg::ANGLE_W-1:0] angle_start;
	logic [esa_pkg::ANGLE_W-1:0] angle_end;
	logic read_error;
	logic [esa_pkg::TIME_W-1:0] elapsed_us;

	modport source(output valid, output angle_start, output angle_end, output read_error,
		output elapsed_us, input ready);
	modport sink(input valid, input angle_start, input angle_end, input read_error,
		input elapsed_us, output ready);
endinterface

[rtl/esa_result_if.sv]
interface esa_result_if;
	logic valid;
	logic ready;
	logic signed [esa_pkg::SPEED_W-1:0] speed_q8;
	logic zero_time_fault;

	modport source(output valid, output speed_q8, output zero_time_fault, input ready);
	modport sink(input valid, input speed_q8, input zero_time_fault, output ready);
endinterface

[rtl/esa_ctrl.sv]
module esa_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  esa_pkg::stat_t stat,
	output esa_pkg::cmd_t cmd
);

	localparam logic [esa_pkg::STEP_W-1:0] DIV_LAST = esa_pkg::STEP_W'(esa_pkg::DIV_STEPS - 1);

	esa_pkg::state_t state_q, state_d;
	logic [esa_pkg::STEP_W-1:0] step_q;
	logic out_valid_q;

	// State register, divide step counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= esa_pkg::ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		cmd       = '0;
		case (state_q)
			esa_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.accum = in_valid;
				if (in_valid && stat.window_done) begin
					state_d = esa_pkg::ST_LOAD;
				end
			end
			esa_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = esa_pkg::ST_DIVIDE;
			end
			esa_pkg::ST_DIVIDE: begin
				cmd.step = 1'b1;
				if (step_q == DIV_LAST) begin
					state_d = esa_pkg::ST_EMIT;
				end
			end
			esa_pkg::ST_EMIT: begin
				// Hold until the result register is free
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = esa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = esa_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/esa_datapath.sv]
module esa_datapath #(
	parameter int SAMPLES = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wen,
	input  logic [esa_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [esa_pkg::CFG_W-1:0] cfg_data,
	input  logic [esa_pkg::ANGLE_W-1:0] angle_start,
	input  logic [esa_pkg::ANGLE_W-1:0] angle_end,
	input  logic read_error,
	input  logic [esa_pkg::TIME_W-1:0] elapsed_us,
	input  esa_pkg::cmd_t cmd,
	output esa_pkg::stat_t stat,
	output logic signed [esa_pkg::SPEED_W-1:0] speed_q8,
	output logic zero_time_fault
);

	localparam logic [esa_pkg::COUNT_W-1:0] COUNT_LAST = esa_pkg::COUNT_W'(SAMPLES - 1);

	logic [esa_pkg::TIME_W-1:0] max_interval_q;
	logic [esa_pkg::ANGLE_W-1:0] wrap_threshold_q;
	logic [esa_pkg::COUNT_W-1:0] count_q;
	logic signed [esa_pkg::ASUM_W-1:0] angle_sum_q;
	logic [esa_pkg::TSUM_W-1:0] time_sum_q;

	logic [esa_pkg::NUM_W-1:0] num_q;
	logic [esa_pkg::DEN_W-1:0] den_q;
	logic [esa_pkg::DEN_W-1:0] rem_q;
	logic [esa_pkg::QUO_W-1:0] quo_q;
	logic ovf_q;
	logic neg_q;
	logic zero_q;
	logic signed [esa_pkg::SPEED_W-1:0] speed_q;
	logic fault_q;

	logic item_ok;
	logic signed [esa_pkg::DIFF_W-1:0] diff_raw, diff_fix, thr_s;
	logic [esa_pkg::MAG_W-1:0] mag;
	logic [esa_pkg::DEN_W:0] trial;
	logic trial_ge;
	logic [esa_pkg::QUO_W-1:0] limit, mag_sat;
	logic [esa_pkg::SPEED_W-1:0] speed_mag;

	// Filter the pair and correct the difference for a zero crossing
	always_comb begin
		item_ok  = !read_error && (elapsed_us <= max_interval_q);
		thr_s    = $signed({2'b00, wrap_threshold_q});
		diff_raw = $signed({2'b00, angle_start}) - $signed({2'b00, angle_end});
		if (diff_raw < -thr_s) begin
			diff_fix = diff_raw + $signed(esa_pkg::ANGLE_SPAN);
		end else if (diff_raw > thr_s) begin
			diff_fix = diff_raw - $signed(esa_pkg::ANGLE_SPAN);
		end else begin
			diff_fix = diff_raw;
		end
	end

	assign stat.window_done = item_ok && (count_q == COUNT_LAST);

	// Configuration registers and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_interval_q   <= esa_pkg::MAX_INTERVAL_RST;
			wrap_threshold_q <= esa_pkg::WRAP_THRESHOLD_RST;
			count_q          <= '0;
			angle_sum_q      <= '0;
			time_sum_q       <= '0;
		end else begin
			if (cfg_wen) begin
				case (cfg_idx)
					esa_pkg::REG_MAX_INTERVAL:   max_interval_q <= cfg_data;
					esa_pkg::REG_WRAP_THRESHOLD: wrap_threshold_q <= cfg_data[esa_pkg::ANGLE_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				count_q     <= '0;
				angle_sum_q <= '0;
				time_sum_q  <= '0;
			end else if (cmd.accum && item_ok) begin
				count_q     <= count_q + 1'b1;
				angle_sum_q <= angle_sum_q + esa_pkg::ASUM_W'(diff_fix);
				time_sum_q  <= time_sum_q + esa_pkg::TSUM_W'(elapsed_us);
			end
		end
	end

	// Magnitude of the angle sum and one restoring divide step
	always_comb begin
		mag      = angle_sum_q[esa_pkg::ASUM_W-1] ? esa_pkg::MAG_W'(-angle_sum_q)
			: esa_pkg::MAG_W'(angle_sum_q);
		trial    = {rem_q, num_q[esa_pkg::NUM_W-1]};
		trial_ge = trial >= {1'b0, den_q};
	end

	// Saturate the quotient and apply the sign
	always_comb begin
		limit = neg_q ? esa_pkg::SPEED_NEG_MAX : esa_pkg::SPEED_POS_MAX;
		if (ovf_q || (quo_q > limit)) begin
			mag_sat = limit;
		end else begin
			mag_sat = quo_q;
		end
		speed_mag = mag_sat[esa_pkg::SPEED_W-1:0];
	end

	// Load operands, iterate the divider, capture the result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q  <= esa_pkg::NUM_W'(mag) * esa_pkg::NUM_W'(esa_pkg::NUM_SCALE);
			den_q  <= {time_sum_q, 14'b0} - esa_pkg::DEN_W'(time_sum_q);
			neg_q  <= angle_sum_q[esa_pkg::ASUM_W-1];
			zero_q <= (time_sum_q == '0);
			rem_q  <= '0;
			quo_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.step) begin
			num_q <= {num_q[esa_pkg::NUM_W-2:0], 1'b0};
			rem_q <= trial_ge ? esa_pkg::DEN_W'(trial - {1'b0, den_q})
				: trial[esa_pkg::DEN_W-1:0];
			quo_q <= {quo_q[esa_pkg::QUO_W-2:0], trial_ge};
			ovf_q <= ovf_q | quo_q[esa_pkg::QUO_W-1];
		end
		if (cmd.emit) begin
			if (zero_q) begin
				speed_q <= '0;
			end else begin
				speed_q <= neg_q ? $signed(-speed_mag) : $signed(speed_mag);
			end
			fault_q <= zero_q;
		end
	end

	assign speed_q8        = speed_q;
	assign zero_time_fault = fault_q;

endmodule

[rtl/encoder_speed_averager.sv]
// Encoder speed averager. Each request on pair carries two angle readings, an error
// flag and the microseconds between the readings; a pair with an error or a time above
// max_interval_us is dropped. Accepted pairs add their wrap-corrected, inverted angle
// difference and their time to running sums. After SAMPLES accepted pairs one result
// request on result carries the speed in revolutions per second, signed Q8, truncated
// and saturated, or zero_time_fault when the summed time is zero. A pair that does not
// close a window leaves the block ready for the next pair. The pair that closes a window
// is followed by pair.ready low (operand load, 49 steps of a one-bit restoring divider,
// result capture), and the capture stretches while an earlier result is still waiting
// on result.ready. The result waits in an output register while new pairs are taken.
// Registers are written by cfg_wen/cfg_idx/cfg_data:
// index 0 max_interval_us (reset 2500), index 1 wrap_threshold (reset 10467).
module encoder_speed_averager #(
	parameter int SAMPLES = 8
) (
	input  logic clk,
	input  logic arst_n,
	esa_pair_if.sink pair,
	esa_result_if.source result,
	input  logic cfg_wen,
	input  logic [esa_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [esa_pkg::CFG_W-1:0] cfg_data
);

	esa_pkg::cmd_t cmd;
	esa_pkg::stat_t stat;

	esa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pair.valid),
		.in_ready  (pair.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	esa_datapath #(
		.SAMPLES (SAMPLES)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_idx         (cfg_idx),
		.cfg_data        (cfg_data),
		.angle_start     (pair.angle_start),
		.angle_end       (pair.angle_end),
		.read_error      (pair.read_error),
		.elapsed_us      (pair.elapsed_us),
		.cmd             (cmd),
		.stat            (stat),
		.speed_q8        (result.speed_q8),
		.zero_time_fault (result.zero_time_fault)
	);

endmodule

[rtl/esa_checker.sv]
`include "encoder_speed_averager_macros.svh"

module esa_checker (
	input logic clk,
	input logic arst_n,
	input logic pair_valid,
	input logic pair_ready,
	input logic result_valid,
	input logic result_ready,
	input logic [esa_pkg::SPEED_W-1:0] speed_q8,
	input logic zero_time_fault
);

	// A stalled result holds its payload
	`ESA_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(speed_q8) && $stable(zero_time_fault), "result changed while stalled")

	// A fault result carries zero speed
	`ESA_ASSERT_SAME(a_fault_zero, result_valid && zero_time_fault, speed_q8 == '0, "fault result with nonzero speed")

	// Pairs are held off only after a request closed a window
	`ESA_ASSERT_SAME(a_ready_fall, $fell(pair_ready), $past(pair_valid), "pair input held off without a request")

	// A new result follows the divider, during which pairs are held off
	`ESA_ASSERT_SAME(a_result_after_div, $rose(result_valid), !$past(pair_ready), "result without a divide phase")

endmodule

bind encoder_speed_averager esa_checker u_esa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.pair_valid      (pair.valid),
	.pair_ready      (pair.ready),
	.result_valid    (result.valid),
	.result_ready    (result.ready),
	.speed_q8        (result.speed_q8),
	.zero_time_fault (result.zero_time_fault)
);

[bench/tb_encoder_speed_averager.sv]
module tb_encoder_speed_averager;

	localparam int SAMPLES = 8;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_CYCLES = 1500;
	localparam int PHASE_PAIRS = 85;
	localparam longint SPAN = 16383;
	localparam longint SCALE = 256000000;
	localparam longint POS_LIMIT = 8388607;
	localparam longint NEG_LIMIT = 8388608;

	typedef struct {
		logic [esa_pkg::ANGLE_W-1:0] angle_start;
		logic [esa_pkg::ANGLE_W-1:0] angle_end;
		logic read_error;
		logic [esa_pkg::TIME_W-1:0] elapsed_us;
	} pair_req_t;

	typedef struct {
		logic signed [esa_pkg::SPEED_W-1:0] speed_q8;
		logic zero_time_fault;
	} speed_res_t;

	typedef struct {
		logic [esa_pkg::TIME_W-1:0] max_interval;
		logic [esa_pkg::ANGLE_W-1:0] wrap_thr;
	} reg_set_t;

	// Tracks the averaging window and holds the speeds still owed by the block
	class speed_window_tracker;
		logic [esa_pkg::TIME_W-1:0] max_interval;
		logic [esa_pkg::ANGLE_W-1:0] wrap_thr;
		int unsigned in_window;
		longint angle_sum;
		longint time_sum;
		speed_res_t speed_due[$];
		int unsigned pairs_seen;
		int unsigned pairs_dropped;
		int unsigned speeds_checked;
		int unsigned faults_seen;
		int unsigned saturated_seen;
		int unsigned errors;

		function new();
			max_interval = esa_pkg::MAX_INTERVAL_RST;
			wrap_thr = esa_pkg::WRAP_THRESHOLD_RST;
		endfunction

		function void set_reg(logic [esa_pkg::CFG_IDX_W-1:0] idx,
			logic [esa_pkg::CFG_W-1:0] data);
			case (idx)
				esa_pkg::REG_MAX_INTERVAL: max_interval = data[esa_pkg::TIME_W-1:0];
				esa_pkg::REG_WRAP_THRESHOLD: wrap_thr = data[esa_pkg::ANGLE_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_pair(pair_req_t p);
			longint diff;
			longint mag;
			longint q;
			bit neg;
			speed_res_t r;
			pairs_seen++;
			// drop errored or late pairs
			if (p.read_error || p.elapsed_us > max_interval) begin
				pairs_dropped++;
				return;
			end
			// inverted difference, folded back across the zero crossing
			diff = longint'(p.angle_start) - longint'(p.angle_end);
			if (diff < -longint'(wrap_thr))
				diff += SPAN;
			else if (diff > longint'(wrap_thr))
				diff -= SPAN;
			angle_sum += diff;
			time_sum += p.elapsed_us;
			in_window++;
			if (in_window < SAMPLES)
				return;
			// close the window: divide, truncate, saturate
			if (time_sum == 0) begin
				r.speed_q8 = '0;
				r.zero_time_fault = 1'b1;
			end else begin
				neg = angle_sum < 0;
				mag = neg ? -angle_sum : angle_sum;
				q = (mag * SCALE) / (SPAN * time_sum);
				if (neg && q > NEG_LIMIT)
					q = NEG_LIMIT;
				else if (!neg && q > POS_LIMIT)
					q = POS_LIMIT;
				r.speed_q8 = neg ? esa_pkg::SPEED_W'(-q) : esa_pkg::SPEED_W'(q);
				r.zero_time_fault = 1'b0;
			end
			speed_due.push_back(r);
			in_window = 0;
			angle_sum = 0;
			time_sum = 0;
		endfunction

		function void check_speed(logic signed [esa_pkg::SPEED_W-1:0] speed, logic fault);
			speed_res_t exp_r;
			if (speed_due.size() == 0) begin
				$display("%0t: unexpected speed result %0d fault %0b", $time, speed, fault);
				errors++;
				return;
			end
			exp_r = speed_due.pop_front();
			speeds_checked++;
			if (exp_r.zero_time_fault)
				faults_seen++;
			if (exp_r.speed_q8 == esa_pkg::SPEED_W'(POS_LIMIT)
				|| exp_r.speed_q8 == esa_pkg::SPEED_W'(-NEG_LIMIT))
				saturated_seen++;
			if (speed !== exp_r.speed_q8) begin
				$display("%0t: speed_q8 expected %0d got %0d", $time, exp_r.speed_q8, speed);
				errors++;
			end
			if (fault !== exp_r.zero_time_fault) begin
				$display("%0t: zero_time_fault expected %0b got %0b", $time,
					exp_r.zero_time_fault, fault);
				errors++;
			end
		endfunction

		function int pending();
			return speed_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [esa_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [esa_pkg::CFG_W-1:0] cfg_data;
	bit hold_req;
	bit steady;

	esa_pair_if pair_if();
	esa_result_if result_if();

	speed_window_tracker tracker = new();

	encoder_speed_averager #(
		.SAMPLES(SAMPLES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pair(pair_if),
		.result(result_if),
		.cfg_wen(cfg_wen),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic pair_req_t mk_pair(int a0, int a1, bit err, int dt);
		pair_req_t p;
		p.angle_start = esa_pkg::ANGLE_W'(a0);
		p.angle_end = esa_pkg::ANGLE_W'(a1);
		p.read_error = err;
		p.elapsed_us = esa_pkg::TIME_W'(dt);
		return p;
	endfunction

	// Mostly nearby readings, with times mostly within the current limit and some above it
	function automatic pair_req_t rand_pair(logic [esa_pkg::TIME_W-1:0] lim);
		pair_req_t p;
		int r;
		p.angle_start = esa_pkg::ANGLE_W'($urandom_range(0, 16383));
		if ($urandom_range(0, 99) < 70)
			p.angle_end = p.angle_start + esa_pkg::ANGLE_W'($urandom_range(0, 1200) - 600);
		else
			p.angle_end = esa_pkg::ANGLE_W'($urandom_range(0, 16383));
		p.read_error = ($urandom_range(0, 9) == 0);
		r = $urandom_range(0, 99);
		if (r < 5)
			p.elapsed_us = '0;
		else if (r < 10)
			p.elapsed_us = lim;
		else if (r < 18 && lim != 16'hFFFF)
			p.elapsed_us = esa_pkg::TIME_W'($urandom_range(int'(lim) + 1, 65535));
		else
			p.elapsed_us = esa_pkg::TIME_W'($urandom_range(0, int'(lim)));
		return p;
	endfunction

	// Offer one request after a gap and hold it until taken
	task automatic send_pair(input pair_req_t p, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			pair_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pair_if.valid = 1'b1;
		pair_if.angle_start = p.angle_start;
		pair_if.angle_end = p.angle_end;
		pair_if.read_error = p.read_error;
		pair_if.elapsed_us = p.elapsed_us;
		do @(posedge clk); while (!pair_if.ready);
		tracker.take_pair(p);
	endtask

	task automatic write_reg(input logic [esa_pkg::CFG_IDX_W-1:0] idx,
		input logic [esa_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_wen = 1'b1;
		cfg_idx = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_wen = 1'b0;
		tracker.set_reg(idx, data);
	endtask

	// Idle the input and wait for every owed speed plus the divider's tail
	task automatic drain();
		@(negedge clk);
		pair_if.valid = 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Result side: random stalls, one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		result_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_if.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (stall_left > 0) begin
				result_if.ready = 1'b0;
				stall_left--;
			end else if (steady) begin
				result_if.ready = 1'b1;
			end else begin
				stall_left = gap_len();
				result_if.ready = (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// Check each speed result taken
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && result_if.valid && result_if.ready)
				tracker.check_speed(result_if.speed_q8, result_if.zero_time_fault);
		end
	end

	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		pair_req_t directed[$];
		reg_set_t settings[7];
		pair_req_t p;
		pair_if.valid = 1'b0;
		pair_if.angle_start = '0;
		pair_if.angle_end = '0;
		pair_if.read_error = 1'b0;
		pair_if.elapsed_us = '0;
		cfg_wen = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		hold_req = 1'b0;
		steady = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Mixed window under reset registers: limits, drops, wrap both ways
		directed.push_back(mk_pair(0, 16383, 0, 2500));
		directed.push_back(mk_pair(16383, 0, 0, 0));
		directed.push_back(mk_pair(5000, 0, 1, 100));
		directed.push_back(mk_pair(100, 200, 0, 2501));
		directed.push_back(mk_pair(12000, 1000, 0, 65535));
		directed.push_back(mk_pair(10467, 0, 0, 2500));
		directed.push_back(mk_pair(0, 10468, 0, 2500));
		directed.push_back(mk_pair(3000, 2000, 0, 1234));
		directed.push_back(mk_pair(2000, 3000, 0, 777));
		directed.push_back(mk_pair(16383, 16383, 0, 1));
		directed.push_back(mk_pair(0, 0, 0, 2500));
		// Positive then negative saturation
		for (int i = 0; i < SAMPLES; i++)
			directed.push_back(mk_pair(10000, 0, 0, (i == 0) ? 1 : 0));
		for (int i = 0; i < SAMPLES; i++)
			directed.push_back(mk_pair(0, 10000, 0, 1));
		foreach (directed[i])
			send_pair(directed[i], gap_len());

		settings[0] = '{16'd2500, 14'd10467};
		settings[1] = '{16'd65535, 14'd16383};
		settings[2] = '{16'd0, 14'd0};
		settings[3] = '{16'd65535, 14'd0};
		settings[4] = '{esa_pkg::TIME_W'($urandom_range(1, 65534)),
			esa_pkg::ANGLE_W'($urandom_range(1, 16382))};
		settings[5] = '{16'd1000, 14'd8191};
		settings[6] = '{16'd300, 14'd16383};

		foreach (settings[ph]) begin
			drain();
			write_reg(esa_pkg::REG_MAX_INTERVAL, esa_pkg::CFG_W'(settings[ph].max_interval));
			write_reg(esa_pkg::REG_WRAP_THRESHOLD, esa_pkg::CFG_W'(settings[ph].wrap_thr));
			steady = (ph == 3);
			for (int n = 0; n < PHASE_PAIRS; n++) begin
				// long result hold-off so the block backs up into the input
				if (ph == 1 && n == 10)
					hold_req = 1'b1;
				p = rand_pair(tracker.max_interval);
				send_pair(p, steady ? 0 : gap_len());
			end
		end
		steady = 1'b0;
		drain();

		$display("Pairs offered: %0d, dropped: %0d, register settings: %0d",
			tracker.pairs_seen, tracker.pairs_dropped, $size(settings) + 1);
		$display("Speeds checked: %0d, zero-time faults: %0d, saturated: %0d",
			tracker.speeds_checked, tracker.faults_seen, tracker.saturated_seen);
		if (tracker.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
